// File: hdl/tpq_pkg.sv
// Shared types and codes for the time-ordered priority queue.
package tpq_pkg;

   localparam int TIME_W = 16;
   localparam int TAG_W  = 8;
   localparam int CAP_W  = 5;
   localparam int CNT_W  = 5;
   localparam int STAT_W = 2;

   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] entry_time;
      logic [TAG_W-1:0]  entry_tag;
   } entry_type;

   // Command broadcast to every cell of the chain in the cycle of a transaction.
   typedef struct packed {
      logic      enq_en;
      logic      deq_en;
      entry_type entry;
   } cmd_type;

endpackage

// File: hdl/tpq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module tpq_cell (
   input  logic               clock,
   input  tpq_pkg::cmd_type   cmd,
   input  logic               occupied,
   input  logic               left_le,
   input  tpq_pkg::entry_type left_entry,
   input  tpq_pkg::entry_type right_entry,
   output tpq_pkg::entry_type entry,
   output logic               le
);
   import tpq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // A slot holding a time not above the new key keeps its place on an insert.
   assign le    = occupied && (entry_ff.entry_time <= cmd.entry.entry_time);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq_en && !le) begin
         entry_in = left_le ? cmd.entry : left_entry;
      end else if (cmd.deq_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hdl/time_ordered_priority_queue_unit.sv
// Time-ordered priority queue: a chain of DEPTH cells kept sorted by ascending time.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one enqueue or dequeue per cycle unless stalled; all cells compare and shift in parallel.
// A request enters only while the output register is empty or its result is taken in the same cycle.
// Reset (synchronous, active high) empties the queue and sets capacity to 16.
module time_ordered_priority_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: entry_time [15:0], entry_tag [23:16]
   input  logic [23:0]              req_tdata,
   // req_tuser: func
   input  logic                     req_tuser,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // rsp_tdata: out_time [15:0], out_tag [23:16], status [25:24], count [30:26], zero [31]
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [tpq_pkg::CAP_W-1:0] csr_data,
   input  logic                     csr_valid,
   output logic                     csr_ready
);
   import tpq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > CAP_W) ? CW : CAP_W;

   logic [CAP_W-1:0] capacity_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;

   logic       accept;
   logic       full;
   logic       empty;
   logic [XW-1:0] cap_x, eff_cap;
   cmd_type    cmd;
   entry_type  req_entry;
   entry_type  cell_entry [DEPTH];
   logic       cell_le    [DEPTH];
   entry_type  out_entry;
   logic [STAT_W-1:0] status;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign req_entry.entry_time = req_tdata[TIME_W-1:0];
   assign req_entry.entry_tag  = req_tdata[TIME_W+TAG_W-1:TIME_W];

   // Capacity zero acts as one; capacity above the built depth is clamped.
   always_comb begin
      cap_x = XW'(capacity_ff);
      if (cap_x == '0) begin
         cap_x = XW'(1);
      end
      eff_cap = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
   end

   assign full  = XW'(count_ff) >= eff_cap;
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.enq_en = accept && (req_tuser == FUNC_ENQ) && !full;
      cmd.deq_en = accept && (req_tuser == FUNC_DEQ) && !empty;
      cmd.entry  = req_entry;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_le;
      if (i == 0) begin : g_head
         assign left_entry = req_entry;
         assign left_le    = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_le    = cell_le[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end
      tpq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CW'(i) < count_ff),
         .left_le     (left_le),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .le          (cell_le[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      out_entry = '0;
      status    = ST_DONE;
      if (req_tuser == FUNC_ENQ) begin
         if (full) begin
            status = ST_FULL;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (empty) begin
            status = ST_EMPTY;
         end else begin
            out_entry = cell_entry[0];
            count_in  = count_ff - CW'(1);
         end
      end
      rsp_data_in = {1'b0, CNT_W'(count_in), status, out_entry.entry_tag, out_entry.entry_time};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_W'(16);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the time-ordered priority queue unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 3;

   // Field layout of rsp_tdata, highest bits first.
   typedef struct packed {
      logic              pad;
      logic [CNT_W-1:0]  count;
      logic [STAT_W-1:0] status;
      logic [TAG_W-1:0]  out_tag;
      logic [TIME_W-1:0] out_time;
   } rsp_word_type;

   // Keeps its own sorted copy of the stored entries and the results they imply.
   class sorted_queue_tracker;
      entry_type    held[$];
      rsp_word_type pending_rsp[$];
      int           capacity;
      int           mismatches;

      function new();
         capacity   = DEPTH;
         mismatches = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = int'(value);
      endfunction

      function void note_request(logic func, entry_type entry);
         rsp_word_type res;
         int room;
         int pos;
         res  = '0;
         // A capacity of zero acts as one; anything above the built depth acts as the depth.
         room = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
         if (func == FUNC_ENQ) begin
            if (held.size() >= room) begin
               res.status = ST_FULL;
            end else begin
               // Insert after every entry with an equal time so ties leave in arrival order.
               pos = 0;
               while (pos < held.size() && held[pos].entry_time <= entry.entry_time)
                  pos++;
               held.insert(pos, entry);
            end
         end else if (held.size() == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.out_time = held[0].entry_time;
            res.out_tag  = held[0].entry_tag;
            void'(held.pop_front());
         end
         res.count = CNT_W'(held.size());
         pending_rsp.push_back(res);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(logic [31:0] data);
         rsp_word_type got;
         rsp_word_type want;
         got = data;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, data);
            mismatches++;
            return;
         end
         want = pending_rsp.pop_front();
         compare_field("out_time", 32'(want.out_time), 32'(got.out_time));
         compare_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("count", 32'(want.count), 32'(got.count));
         compare_field("pad", 32'(want.pad), 32'(got.pad));
      endfunction
   endclass

   logic              clock;
   logic              reset      = 1'b1;
   logic [23:0]       req_tdata  = '0;
   logic              req_tuser  = 1'b0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [CAP_W-1:0]  csr_data   = '0;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;

   bit req_burst     = 1'b0;
   bit rsp_burst     = 1'b0;
   bit long_hold_due = 1'b0;

   sorted_queue_tracker tracker = new();

   time_ordered_priority_queue_unit #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_item(logic func, logic [TIME_W-1:0] t, logic [TAG_W-1:0] g);
      int gap;
      entry_type entry;
      gap = req_burst ? 0 : int'($urandom_range(0, 12));
      if (gap > 0) begin
         if (req_tvalid) req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {g, t};
      do @(posedge clock); while (req_tready !== 1'b1);
      entry.entry_time = t;
      entry.entry_tag  = g;
      tracker.note_request(func, entry);
   endtask

   task automatic wait_queue_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      tracker.set_capacity(value);
   endtask

   task automatic run_random_phase(int items, int enq_pct);
      logic              func;
      logic [TIME_W-1:0] t;
      int                pick;
      for (int i = 0; i < items; i++) begin
         func = ($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ;
         pick = int'($urandom_range(0, 9));
         // Narrow times give many ties; the extremes are also picked on purpose now and then.
         if (pick < 4)
            t = TIME_W'($urandom_range(0, 15));
         else if (pick == 4)
            t = ($urandom_range(0, 1) != 0) ? '1 : '0;
         else
            t = TIME_W'($urandom_range(0, 65535));
         send_item(func, t, TAG_W'($urandom_range(0, 255)));
      end
   endtask

   // Result side: random stalls, plus a long hold-off on request so the block backs up.
   initial begin : rsp_side
      int wait_cycles;
      wait (reset === 1'b0);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            wait_cycles = rsp_burst ? 0 : int'($urandom_range(0, 12));
            if (wait_cycles > 0) begin
               rsp_tready <= 1'b0;
               repeat (wait_cycles) @(posedge clock);
            end
         end
         if (!rsp_tready) rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         tracker.check_response(rsp_tdata);
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** time_ordered_priority_queue_unit: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int caps[10];
      caps = '{16, 3, 31, 1, 8, 0, 2, 17, 16, 5};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty dequeue, extremes, equal times in arrival order, then a full drain.
      send_item(FUNC_DEQ, '1, '1);
      send_item(FUNC_ENQ, 16'd100, 8'd1);
      send_item(FUNC_ENQ, 16'hFFFF, 8'hFF);
      send_item(FUNC_ENQ, 16'd0, 8'd0);
      send_item(FUNC_ENQ, 16'd100, 8'd2);
      send_item(FUNC_ENQ, 16'd50, 8'hAA);
      send_item(FUNC_ENQ, 16'd100, 8'd3);
      repeat (6) send_item(FUNC_DEQ, 16'h5555, 8'h55);
      send_item(FUNC_DEQ, 16'h0000, 8'h00);
      wait_queue_idle();

      // Smallest capacity: a second enqueue is refused.
      write_capacity(5'd1);
      send_item(FUNC_ENQ, 16'd7, 8'h5A);
      send_item(FUNC_ENQ, 16'd9, 8'hA5);
      send_item(FUNC_DEQ, 16'd0, 8'd0);
      send_item(FUNC_DEQ, 16'd0, 8'd0);
      wait_queue_idle();

      // A capacity of zero behaves like one.
      write_capacity(5'd0);
      send_item(FUNC_ENQ, 16'd3, 8'h11);
      send_item(FUNC_ENQ, 16'd2, 8'h22);
      send_item(FUNC_DEQ, 16'd0, 8'd0);
      wait_queue_idle();

      // Alternate filling and draining phases; a capacity write may land below the count.
      for (int phase = 0; phase < 10; phase++) begin
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         if (phase == 2 || phase == 7) long_hold_due = 1'b1;
         write_capacity(CAP_W'(caps[phase]));
         run_random_phase(118, (phase % 2 == 0) ? 70 : 30);
         wait_queue_idle();
      end

      if (tracker.mismatches == 0)
         $display("** time_ordered_priority_queue_unit: PASSED **");
      else
         $display("** time_ordered_priority_queue_unit: FAILED **");
      $finish;
   end

endmodule

// File: time_ordered_priority_queue_unit.f
hdl/tpq_pkg.sv
hdl/tpq_cell.sv
hdl/time_ordered_priority_queue_unit.sv
verif/tb.sv
